// File: rtl/wrp_pkg.sv
// Package with the shared constants and types of the weighted random pick unit.
`timescale 1ns / 1ps

package wrp_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int ACCURACY    = 1024;

	localparam int OP_W     = 1;
	localparam int IDX_W    = 6;
	localparam int WEIGHT_W = 17;
	localparam int RAND_W   = 10;
	localparam int CFG_W    = 7;

	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
	localparam int WEIGHT_ONE = 65536;
	localparam int TOTAL_W    = $clog2(MAX_ENTRIES * WEIGHT_ONE + 1);
	localparam int R_W        = $clog2(ACCURACY);
	localparam int TARGET_W   = TOTAL_W + R_W;
	localparam int SCALED_W   = TOTAL_W + $clog2(ACCURACY + 1);

	localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
	localparam logic [OP_W-1:0] OP_CHOOSE = 1'b1;

	typedef struct packed {
		logic                rd_en;
		logic [IDX_W-1:0]    rd_addr;
		logic                wr_en;
		logic [IDX_W-1:0]    wr_addr;
		logic [WEIGHT_W-1:0] wr_data;
	} tbl_req_t;

endpackage

// File: rtl/wrp_if.sv
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps

interface wrp_req_if;
	logic                         valid;
	logic                         ready;
	logic [wrp_pkg::OP_W-1:0]     op;
	logic [wrp_pkg::IDX_W-1:0]    entry_index;
	logic [wrp_pkg::WEIGHT_W-1:0] weight;
	logic [wrp_pkg::RAND_W-1:0]   random_value;

	modport source (output valid, output op, output entry_index, output weight,
		output random_value, input ready);
	modport sink (input valid, input op, input entry_index, input weight,
		input random_value, output ready);
endinterface

interface wrp_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      picked;
	logic [wrp_pkg::IDX_W-1:0] picked_index;

	modport source (output valid, output picked, output picked_index, input ready);
	modport sink (input valid, input picked, input picked_index, output ready);
endinterface

// File: rtl/wrp_table.sv
// Weight table: synchronous memory with one read port and one write port, and per-entry valid bits cleared at reset.
`timescale 1ns / 1ps

module wrp_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wrp_pkg::tbl_req_t            req,
	output logic [wrp_pkg::WEIGHT_W-1:0] rd_data
);

	logic [wrp_pkg::WEIGHT_W-1:0] mem [wrp_pkg::MAX_ENTRIES];
	logic [wrp_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [wrp_pkg::WEIGHT_W-1:0] rd_data_q;
	logic                         rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// File: rtl/weighted_random_pick_unit.sv
// Top level of the weighted random pick unit: control sequencer, weight table and result register.
`timescale 1ns / 1ps

// A load transfer stores one weight, saturated to 1.0, through a read state and a write state
// before the next request can be taken. A choose transfer makes two passes over the first n
// entries in use through the single read port of the weight table: one pass forms the total,
// the second walks the cumulative sum, and the draw is scaled by one multiply between them.
// The walk stops early when it hits; n is at most 64. A finished result waits in an
// output register, so new requests are taken while it is unclaimed; a pick that finishes while
// the previous result is still unclaimed holds its result until the output register frees up.
module weighted_random_pick_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [wrp_pkg::CFG_W-1:0] cfg_wdata,
	wrp_req_if.sink                   req,
	wrp_rsp_if.source                 rsp
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_LOAD_RD = 7'b0000010,
		ST_LOAD_WR = 7'b0000100,
		ST_SUM     = 7'b0001000,
		ST_SCALE   = 7'b0010000,
		ST_WALK    = 7'b0100000,
		ST_FINISH  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [wrp_pkg::CFG_W-1:0]    entries_q;
	logic [wrp_pkg::CNT_W-1:0]    num_used;
	logic [wrp_pkg::IDX_W-1:0]    ld_idx_q;
	logic [wrp_pkg::WEIGHT_W-1:0] ld_weight_q;
	logic [wrp_pkg::R_W-1:0]      r_q;
	logic [wrp_pkg::TOTAL_W-1:0]  weight_total_q;
	logic [wrp_pkg::TOTAL_W-1:0]  sum_q;
	logic [wrp_pkg::TOTAL_W-1:0]  cum_q;
	logic [wrp_pkg::TOTAL_W-1:0]  cum_next;
	logic [wrp_pkg::TOTAL_W-1:0]  scale;
	logic [wrp_pkg::TARGET_W-1:0] target_q;
	logic [wrp_pkg::SCALED_W-1:0] cum_scaled;
	logic [wrp_pkg::CNT_W-1:0]    cnt_q;
	logic                         issue;
	logic                         rd_pend_s1;
	logic [wrp_pkg::IDX_W-1:0]    rd_idx_s1;
	logic                         hit_q;
	logic [wrp_pkg::IDX_W-1:0]    hit_idx_q;
	logic                         rsp_valid_q;
	logic                         picked_q;
	logic [wrp_pkg::IDX_W-1:0]    picked_index_q;
	logic                         req_xfer;
	logic                         sweep_done;
	logic                         hit_now;
	logic                         rsp_load;
	logic [wrp_pkg::WEIGHT_W-1:0] weight_sat;
	logic [wrp_pkg::WEIGHT_W-1:0] rd_data;
	wrp_pkg::tbl_req_t            tbl_req;

	wrp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (rd_data)
	);

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	assign num_used = (entries_q > wrp_pkg::CFG_W'(wrp_pkg::MAX_ENTRIES))
		? wrp_pkg::CNT_W'(wrp_pkg::MAX_ENTRIES) : wrp_pkg::CNT_W'(entries_q);

	assign weight_sat = (req.weight > wrp_pkg::WEIGHT_W'(wrp_pkg::WEIGHT_ONE))
		? wrp_pkg::WEIGHT_W'(wrp_pkg::WEIGHT_ONE) : req.weight;

	assign issue = ((state_q == ST_SUM) || (state_q == ST_WALK)) && (cnt_q < num_used);
	assign sweep_done = (cnt_q >= num_used) && !rd_pend_s1;

	assign cum_next   = cum_q + wrp_pkg::TOTAL_W'(rd_data);
	assign cum_scaled = wrp_pkg::SCALED_W'(cum_next) * wrp_pkg::SCALED_W'(wrp_pkg::ACCURACY);
	assign hit_now    = rd_pend_s1 && (cum_scaled > wrp_pkg::SCALED_W'(target_q));

	assign scale = (sum_q > wrp_pkg::TOTAL_W'(wrp_pkg::WEIGHT_ONE))
		? sum_q : wrp_pkg::TOTAL_W'(wrp_pkg::WEIGHT_ONE);

	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		tbl_req.rd_en   = issue || (state_q == ST_LOAD_RD);
		tbl_req.rd_addr = (state_q == ST_LOAD_RD) ? ld_idx_q : cnt_q[wrp_pkg::IDX_W-1:0];
		tbl_req.wr_en   = (state_q == ST_LOAD_WR);
		tbl_req.wr_addr = ld_idx_q;
		tbl_req.wr_data = ld_weight_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					state_d = (req.op == wrp_pkg::OP_LOAD) ? ST_LOAD_RD : ST_SUM;
				end
			end
			ST_LOAD_RD: state_d = ST_LOAD_WR;
			ST_LOAD_WR: state_d = ST_IDLE;
			ST_SUM: begin
				if (sweep_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_WALK;
			ST_WALK: begin
				if (hit_now || sweep_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			entries_q      <= '0;
			weight_total_q <= '0;
			rd_pend_s1     <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= issue;
			if (cfg_we) begin
				entries_q <= cfg_wdata;
			end
			if (state_q == ST_LOAD_WR) begin
				weight_total_q <= weight_total_q - wrp_pkg::TOTAL_W'(rd_data)
					+ wrp_pkg::TOTAL_W'(ld_weight_q);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			ld_idx_q    <= req.entry_index;
			ld_weight_q <= weight_sat;
			r_q         <= wrp_pkg::R_W'(req.random_value % wrp_pkg::ACCURACY);
			cnt_q       <= '0;
			sum_q       <= '0;
		end
		if (issue) begin
			cnt_q     <= cnt_q + wrp_pkg::CNT_W'(1);
			rd_idx_s1 <= cnt_q[wrp_pkg::IDX_W-1:0];
		end
		if ((state_q == ST_SUM) && rd_pend_s1) begin
			sum_q <= sum_q + wrp_pkg::TOTAL_W'(rd_data);
		end
		if (state_q == ST_SCALE) begin
			target_q <= wrp_pkg::TARGET_W'(r_q) * wrp_pkg::TARGET_W'(scale);
			cnt_q    <= '0;
			cum_q    <= '0;
		end
		if (state_q == ST_WALK) begin
			if (rd_pend_s1) begin
				cum_q <= cum_next;
			end
			if (hit_now) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
			end else if (sweep_done) begin
				hit_q     <= 1'b0;
				hit_idx_q <= '0;
			end
		end
		if (rsp_load) begin
			picked_q       <= hit_q;
			picked_index_q <= hit_idx_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.picked       = picked_q;
	assign rsp.picked_index = picked_index_q;

endmodule

// File: rtl/wrp_checker.sv
// Port-level checker for the weighted random pick unit and its bind statement.
`timescale 1ns / 1ps

module wrp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_picked,
	input logic [wrp_pkg::IDX_W-1:0] rsp_picked_index
);

	// A result without a pick always carries index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_picked) |-> (rsp_picked_index == '0))
		else $error("no-pick result with nonzero index");

	// The unit works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");

	// No request produces a result in the cycle right after its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && !rsp_valid) |=> !rsp_valid)
		else $error("result appeared too early");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_picked) && $stable(rsp_picked_index)))
		else $error("stalled result changed");

endmodule

bind weighted_random_pick_unit wrp_checker u_wrp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_picked       (rsp.picked),
	.rsp_picked_index (rsp.picked_index)
);
